FILE: rtl/core/multiplexed_seven_segment_driver_defines.svh
// ----------------------------------------------------------------------------
// multiplexed seven-segment driver assertion macros
// shared property macros for the display driver checks
// ----------------------------------------------------------------------------
`ifndef MULTIPLEXED_SEVEN_SEGMENT_DRIVER_DEFINES_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_DRIVER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MSD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("msd same-cycle check failed");

// next-cycle implication, disabled during reset
`define MSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("msd next-cycle check failed");

`endif

FILE: rtl/core/msd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_pkg
// widths, constants and register indexes of the seven-segment driver
// ----------------------------------------------------------------------------
package msd_pkg;

	localparam int NOW_W       = 32;
	localparam int SEG_W       = 8;
	localparam int DIGIT_COUNT = 4;
	localparam int DIGIT_W     = $clog2(DIGIT_COUNT);
	localparam int DOT_W       = DIGIT_COUNT;
	localparam int INTERVAL_W  = 16;
	localparam int FRAME_W     = 2 * SEG_W;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = INTERVAL_W;

	localparam logic [SEG_W-1:0] DOT_BIT     = 8'h80;
	localparam logic [SEG_W-1:0] SELECT_BASE = 8'h08;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd5;

	// configuration register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_DIGIT0   = 3'd0,
		REG_DIGIT1   = 3'd1,
		REG_DIGIT2   = 3'd2,
		REG_DIGIT3   = 3'd3,
		REG_DOT_MASK = 3'd4,
		REG_ANODE    = 3'd5,
		REG_ENABLE   = 3'd6,
		REG_INTERVAL = 3'd7
	} cfg_reg_t;

endpackage

FILE: rtl/core/msd_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd channels
// valid/ready channels for time ticks in and serial bits out
// ----------------------------------------------------------------------------

// time tick channel
interface msd_in_if;
	logic                       valid;
	logic                       ready;
	logic [msd_pkg::NOW_W-1:0]  now_ms;

	modport source (output valid, output now_ms, input ready);
	modport sink   (input valid, input now_ms, output ready);
endinterface

// serial bit channel
interface msd_out_if;
	logic                         valid;
	logic                         ready;
	logic                         serial_bit;
	logic [msd_pkg::DIGIT_W-1:0]  digit_index;
	logic                         latch_after;

	modport source (output valid, output serial_bit, output digit_index, output latch_after,
		input ready);
	modport sink   (input valid, input serial_bit, input digit_index, input latch_after,
		output ready);
endinterface

FILE: rtl/core/multiplexed_seven_segment_driver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_driver
// four-digit multiplexed display refresh through two chained shift registers
// ----------------------------------------------------------------------------
// Each tick on in_ch carries the millisecond time. A tick is held in an
// input register; when the display is enabled and the wrapping time since the
// last refresh reaches the refresh interval, the current digit's 16-bit frame
// (segment byte, then one-hot digit select, MSB first) is loaded into the
// output shifter and the digit advances. The shifter sends one bit per out_ch
// transfer; a tick that does not refresh leaves the input register without
// waiting for the shifter. A new tick is taken while the frame is still
// shifting; if it is due a refresh, it waits in the input register until the
// last bit goes. latch_after marks the sixteenth bit of each frame.
`include "multiplexed_seven_segment_driver_defines.svh"

module multiplexed_seven_segment_driver (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [msd_pkg::CFG_ADDR_W-1:0]      cfg_index,
	input  logic [msd_pkg::CFG_DATA_W-1:0]      cfg_data,
	msd_in_if.sink                              in_ch,
	msd_out_if.source                           out_ch
);
	import msd_pkg::*;

	localparam int CNT_W = $clog2(FRAME_W + 1);

	// configuration registers
	logic [SEG_W-1:0]      digit_seg_q [DIGIT_COUNT];
	logic [DOT_W-1:0]      dot_mask_q;
	logic                  common_anode_q;
	logic                  display_enabled_q;
	logic [INTERVAL_W-1:0] interval_q;

	// refresh state
	logic [NOW_W-1:0]      last_refresh_q;
	logic [DIGIT_W-1:0]    current_digit_q;

	// input register
	logic                  valid_s1;
	logic [NOW_W-1:0]      now_ms_s1;

	// output shifter
	logic [FRAME_W-1:0]    shift_q;
	logic [CNT_W-1:0]      bits_left_q;
	logic [DIGIT_W-1:0]    frame_digit_q;

	logic [NOW_W-1:0]      elapsed;
	logic                  refresh_needed;
	logic                  shifter_free;
	logic                  s1_done;
	logic                  load_frame;
	logic                  in_fire;
	logic                  out_fire;
	logic [SEG_W-1:0]      seg_byte;
	logic [SEG_W-1:0]      sel_byte;
	logic [FRAME_W-1:0]    frame;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				digit_seg_q[i] <= '0;
			end
			dot_mask_q         <= '0;
			common_anode_q     <= 1'b0;
			display_enabled_q  <= 1'b1;
			interval_q         <= INTERVAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIGIT0:   digit_seg_q[0]     <= cfg_data[SEG_W-1:0];
				REG_DIGIT1:   digit_seg_q[1]     <= cfg_data[SEG_W-1:0];
				REG_DIGIT2:   digit_seg_q[2]     <= cfg_data[SEG_W-1:0];
				REG_DIGIT3:   digit_seg_q[3]     <= cfg_data[SEG_W-1:0];
				REG_DOT_MASK: dot_mask_q         <= cfg_data[DOT_W-1:0];
				REG_ANODE:    common_anode_q     <= cfg_data[0];
				REG_ENABLE:   display_enabled_q  <= cfg_data[0];
				REG_INTERVAL: interval_q         <= cfg_data[INTERVAL_W-1:0];
				default: ;
			endcase
		end
	end

	// refresh decision and frame build
	always_comb begin
		elapsed        = now_ms_s1 - last_refresh_q;
		refresh_needed = display_enabled_q
			&& (elapsed >= {{(NOW_W-INTERVAL_W){1'b0}}, interval_q});
		seg_byte = digit_seg_q[current_digit_q];
		if (dot_mask_q[current_digit_q]) begin
			seg_byte = seg_byte | DOT_BIT;
		end
		if (common_anode_q) begin
			seg_byte = ~seg_byte;
		end
		sel_byte = SELECT_BASE >> current_digit_q;
		frame    = {seg_byte, sel_byte};
	end

	// handshake control
	assign out_fire     = out_ch.valid && out_ch.ready;
	assign in_fire      = in_ch.valid && in_ch.ready;
	assign shifter_free = (bits_left_q == '0) || ((bits_left_q == CNT_W'(1)) && out_ch.ready);
	assign s1_done      = valid_s1 && (!refresh_needed || shifter_free);
	assign load_frame   = s1_done && refresh_needed;
	assign in_ch.ready  = !valid_s1 || s1_done;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			now_ms_s1 <= in_ch.now_ms;
		end
	end

	// refresh state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_refresh_q  <= '0;
			current_digit_q <= '0;
		end else if (load_frame) begin
			last_refresh_q  <= now_ms_s1;
			current_digit_q <= current_digit_q + DIGIT_W'(1);
		end
	end

	// output shifter, MSB first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_left_q <= '0;
		end else if (load_frame) begin
			bits_left_q <= CNT_W'(FRAME_W);
		end else if (out_fire) begin
			bits_left_q <= bits_left_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_frame) begin
			shift_q       <= frame;
			frame_digit_q <= current_digit_q;
		end else if (out_fire) begin
			shift_q <= {shift_q[FRAME_W-2:0], 1'b0};
		end
	end

	// output transfer
	assign out_ch.valid       = (bits_left_q != '0);
	assign out_ch.serial_bit  = shift_q[FRAME_W-1];
	assign out_ch.digit_index = frame_digit_q;
	assign out_ch.latch_after = (bits_left_q == CNT_W'(1));

	// checks
	`MSD_ASSERT_NEXT(a_load_full, clk, arst_n, load_frame, bits_left_q == CNT_W'(FRAME_W))
	`MSD_ASSERT_NEXT(a_frame_ends, clk, arst_n,
		out_fire && out_ch.latch_after && !load_frame, !out_ch.valid)
	`MSD_ASSERT_NEXT(a_digit_step, clk, arst_n, load_frame,
		current_digit_q == $past(current_digit_q) + DIGIT_W'(1))
	`MSD_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_ch.valid && !out_ch.ready && !load_frame,
		$stable(shift_q) && $stable(bits_left_q))
	`MSD_ASSERT_SAME(a_no_overrun, clk, arst_n, load_frame,
		(bits_left_q == '0) || (bits_left_q == CNT_W'(1) && out_fire))

endmodule

FILE: bench/tb_multiplexed_seven_segment_driver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multiplexed_seven_segment_driver
// Drives millisecond time ticks into the display driver and checks every
// serial bit against a predicted frame (segment byte, then digit select).
// The display is reprogrammed between phases while the block is idle, and
// both channels see random gaps and stalls.
// ----------------------------------------------------------------------------

module tb_multiplexed_seven_segment_driver;

	import msd_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT   = 50000;
	localparam int RANDOM_TICKS  = 200;
	localparam int PHASE_TICKS   = 27;
	localparam int PRINT_LIMIT   = 50;

	typedef struct packed {
		logic               serial_bit;
		logic [DIGIT_W-1:0] digit_index;
		logic               latch_after;
	} serial_beat_t;

	// frame predictor and serial bit checker
	class segment_scoreboard;
		logic [SEG_W-1:0]      segments [DIGIT_COUNT];
		logic [DOT_W-1:0]      dots;
		logic                  anode;
		logic                  enabled;
		logic [INTERVAL_W-1:0] interval;
		logic [NOW_W-1:0]      last_refresh;
		logic [DIGIT_W-1:0]    digit;
		serial_beat_t          pending_bits [$];
		int                    mismatches;

		function new();
			foreach (segments[i])
				segments[i] = '0;
			dots         = '0;
			anode        = 1'b0;
			enabled      = 1'b1;
			interval     = INTERVAL_RESET;
			last_refresh = '0;
			digit        = '0;
			mismatches   = 0;
		endfunction

		// register writes drop bits beyond the register width
		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_DIGIT0:   segments[0] = data[SEG_W-1:0];
				REG_DIGIT1:   segments[1] = data[SEG_W-1:0];
				REG_DIGIT2:   segments[2] = data[SEG_W-1:0];
				REG_DIGIT3:   segments[3] = data[SEG_W-1:0];
				REG_DOT_MASK: dots = data[DOT_W-1:0];
				REG_ANODE:    anode = data[0];
				REG_ENABLE:   enabled = data[0];
				REG_INTERVAL: interval = data[INTERVAL_W-1:0];
				default: ;
			endcase
		endfunction

		// accepted tick: queue the sixteen bits of a refresh, if one is due
		function void predict_refresh(logic [NOW_W-1:0] now);
			logic [NOW_W-1:0]   elapsed;
			logic [SEG_W-1:0]   seg;
			logic [SEG_W-1:0]   sel;
			logic [FRAME_W-1:0] frame;
			serial_beat_t       beat;
			int                 k;
			if (!enabled)
				return;
			elapsed = now - last_refresh;
			if (elapsed < NOW_W'(interval))
				return;
			last_refresh = now;
			seg = segments[digit];
			// dot goes in before the common anode inversion
			if (dots[digit])
				seg = seg | DOT_BIT;
			if (anode)
				seg = ~seg;
			sel   = SELECT_BASE >> digit;
			frame = {seg, sel};
			for (k = FRAME_W - 1; k >= 0; k--) begin
				beat.serial_bit  = frame[k];
				beat.digit_index = digit;
				beat.latch_after = (k == 0);
				pending_bits.push_back(beat);
			end
			digit = digit + 1'b1;
		endfunction

		task flag_mismatch(string msg);
			mismatches++;
			if (mismatches <= PRINT_LIMIT)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_serial_bit(serial_beat_t got);
			serial_beat_t want;
			if (pending_bits.size() == 0) begin
				flag_mismatch($sformatf("unexpected bit %0b digit %0d latch %0b",
					got.serial_bit, got.digit_index, got.latch_after));
				return;
			end
			want = pending_bits.pop_front();
			if (got.serial_bit !== want.serial_bit)
				flag_mismatch($sformatf("serial_bit %0b, want %0b",
					got.serial_bit, want.serial_bit));
			if (got.digit_index !== want.digit_index)
				flag_mismatch($sformatf("digit_index %0d, want %0d",
					got.digit_index, want.digit_index));
			if (got.latch_after !== want.latch_after)
				flag_mismatch($sformatf("latch_after %0b, want %0b",
					got.latch_after, want.latch_after));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	msd_in_if  tick_ch ();
	msd_out_if bit_ch ();

	multiplexed_seven_segment_driver u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (tick_ch),
		.out_ch    (bit_ch)
	);

	segment_scoreboard scoreboard = new();

	// display settings for the next phase
	logic [SEG_W-1:0]      cfg_segs [DIGIT_COUNT];
	logic [DOT_W-1:0]      cfg_dots;
	logic                  cfg_anode;
	logic                  cfg_enable;
	logic [INTERVAL_W-1:0] cfg_interval;

	logic [NOW_W-1:0] tick_ms;
	bit               steady;
	int               stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, a few long ones, none during steady stretches
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// time advance: around the interval, on its boundary, or a far jump
	function automatic logic [NOW_W-1:0] pick_step(logic [INTERVAL_W-1:0] ival);
		int unsigned r;
		int unsigned span;
		r    = $urandom_range(0, 99);
		span = 32'(ival);
		if (r < 65)
			return $urandom_range(0, span + span / 2 + 2);
		if (r < 75 || span == 0)
			return span;
		if (r < 85)
			return span - 1;
		return $urandom;
	endfunction

	task send_tick(logic [NOW_W-1:0] now);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid  <= 1'b1;
		tick_ch.now_ms <= now;
		do @(posedge clk); while (!tick_ch.ready);
		scoreboard.predict_refresh(now);
	endtask

	// write every register from the cfg_* settings, junk above each width
	task apply_config();
		cfg_reg_t              idx;
		logic [CFG_DATA_W-1:0] data;
		idx = idx.first();
		repeat (idx.num()) begin
			data = CFG_DATA_W'($urandom);
			case (idx)
				REG_DIGIT0:   data[SEG_W-1:0] = cfg_segs[0];
				REG_DIGIT1:   data[SEG_W-1:0] = cfg_segs[1];
				REG_DIGIT2:   data[SEG_W-1:0] = cfg_segs[2];
				REG_DIGIT3:   data[SEG_W-1:0] = cfg_segs[3];
				REG_DOT_MASK: data[DOT_W-1:0] = cfg_dots;
				REG_ANODE:    data[0] = cfg_anode;
				REG_ENABLE:   data[0] = cfg_enable;
				REG_INTERVAL: data = cfg_interval;
				default: ;
			endcase
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= data;
			scoreboard.write_reg(idx, data);
			@(posedge clk);
			idx = idx.next();
		end
		cfg_we <= 1'b0;
	endtask

	// wait for every predicted bit, then let a non-refreshing tick retire
	task wait_drained();
		int cycles;
		cycles = 0;
		tick_ch.valid <= 1'b0;
		while (scoreboard.pending_bits.size() != 0 && cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		if (scoreboard.pending_bits.size() != 0)
			scoreboard.flag_mismatch($sformatf("%0d bits never arrived",
				scoreboard.pending_bits.size()));
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task set_display(logic [SEG_W-1:0] s0, logic [SEG_W-1:0] s1, logic [SEG_W-1:0] s2,
		logic [SEG_W-1:0] s3, logic [DOT_W-1:0] dots, logic anode, logic enable,
		logic [INTERVAL_W-1:0] ival);
		cfg_segs[0]  = s0;
		cfg_segs[1]  = s1;
		cfg_segs[2]  = s2;
		cfg_segs[3]  = s3;
		cfg_dots     = dots;
		cfg_anode    = anode;
		cfg_enable   = enable;
		cfg_interval = ival;
		apply_config();
	endtask

	// output side: check each transfer, stall at random
	always @(posedge clk) begin
		if (!arst_n) begin
			bit_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (bit_ch.valid && bit_ch.ready) begin
				scoreboard.check_serial_bit({bit_ch.serial_bit, bit_ch.digit_index,
					bit_ch.latch_after});
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				bit_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				bit_ch.ready <= 1'b1;
			end
		end
	end

	// run limit
	initial begin
		#10_000_000;
		$display("tb_multiplexed_seven_segment_driver failed");
		$finish;
	end

	initial begin
		int counted;
		int n;
		int unsigned r;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_DIGIT0;
		cfg_data       = '0;
		tick_ch.valid  = 1'b0;
		tick_ch.now_ms = '0;
		bit_ch.ready   = 1'b0;
		steady         = 1'b0;
		stall_left     = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: interval of five, blank segments
		send_tick(32'd0);
		send_tick(32'd4);
		send_tick(32'd5);
		send_tick(32'd9);
		send_tick(32'd10);
		wait_drained();

		// zero interval refreshes on every tick, all four digits in turn
		set_display(8'hFF, 8'h00, 8'hA5, 8'h5A, 4'b1010, 1'b0, 1'b1, 16'd0);
		send_tick(32'd10);
		send_tick(32'd10);
		send_tick(32'd11);
		send_tick(32'd12);
		wait_drained();

		// widest interval, dots under common anode, time wrapping past zero
		set_display(8'h00, 8'hFF, 8'h7F, 8'h80, 4'b1111, 1'b1, 1'b1, 16'hFFFF);
		send_tick(32'hFFFF_0000);
		send_tick(32'hFFFF_FFFE);
		send_tick(32'hFFFF_FFFF);
		send_tick(32'h0000_FFFD);
		send_tick(32'h0000_FFFE);
		wait_drained();

		// disabled display ignores every tick
		set_display(8'h3F, 8'h06, 8'h5B, 8'h4F, 4'b0101, 1'b0, 1'b0, 16'd0);
		send_tick(32'hFFFF_FFFF);
		send_tick(32'd0);
		send_tick($urandom);
		wait_drained();

		// random phases with fresh settings each time
		tick_ms = 32'h0001_0000;
		counted = 0;
		while (counted < RANDOM_TICKS) begin
			r = $urandom_range(0, 9);
			if (r < 2)
				cfg_interval = 16'd0;
			else if (r < 3)
				cfg_interval = 16'hFFFF;
			else if (r < 8)
				cfg_interval = INTERVAL_W'($urandom_range(1, 12));
			else
				cfg_interval = INTERVAL_W'($urandom_range(13, 65534));
			foreach (cfg_segs[i])
				cfg_segs[i] = SEG_W'($urandom);
			cfg_dots   = DOT_W'($urandom);
			cfg_anode  = 1'($urandom);
			cfg_enable = ($urandom_range(0, 7) != 0);
			apply_config();
			steady = ($urandom_range(0, 3) == 0);
			for (n = 0; n < PHASE_TICKS; n++) begin
				tick_ms = tick_ms + pick_step(cfg_interval);
				send_tick(tick_ms);
			end
			counted += PHASE_TICKS;
			wait_drained();
			steady = 1'b0;
		end

		repeat (20) @(posedge clk);
		if (scoreboard.mismatches == 0 && scoreboard.pending_bits.size() == 0)
			$display("tb_multiplexed_seven_segment_driver passed");
		else
			$display("tb_multiplexed_seven_segment_driver failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/msd_pkg.sv
rtl/core/msd_channels.sv
rtl/core/multiplexed_seven_segment_driver.sv
bench/tb_multiplexed_seven_segment_driver.sv
